// File: rtl/core/epta_pkg.sv
// ----------------------------------------------------------------------------
// epta_pkg: shared types and constants for the polarity transition detector
// Field layouts, state codes, configuration indexes and sizing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package epta_pkg;

  localparam int COORD_BITS       = 7;
  localparam int EVENTS_PER_BATCH = 4;
  localparam int FIELD_COORD_W    = 7;

  localparam int ADDR_W = 2 * COORD_BITS;
  localparam int PIXELS = 1 << ADDR_W;

  localparam int COUNT_W  = 10;
  localparam int MARGIN_W = 10;
  localparam int WIN_W    = 16;
  localparam int SEQ_W    = 4;
  localparam int VERD_W   = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam int BATCH_CNT_W = (EVENTS_PER_BATCH > 1) ? $clog2(EVENTS_PER_BATCH) : 1;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [WIN_W-1:0]    WIN_BATCHES_RESET = 16'd256;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET      = 10'd16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    POL_UNSEEN = 2'd0,
    POL_OFF    = 2'd1,
    POL_ON     = 2'd2
  } pol_code_t;

  typedef enum logic [1:0] {
    TRANS_NONE = 2'd0,
    TRANS_FWD  = 2'd1,
    TRANS_REV  = 2'd2
  } trans_t;

  typedef enum logic [VERD_W-1:0] {
    VERDICT_UNDECIDED = 2'd0,
    VERDICT_FWD       = 2'd1,
    VERDICT_BWD       = 2'd2
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_BATCHES = 1'b0,
    CFG_MARGIN         = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [FIELD_COORD_W-1:0] pixel_x;
    logic [FIELD_COORD_W-1:0] pixel_y;
    logic                     polarity;
  } epta_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] fwd_count;
    logic [COUNT_W-1:0] rev_count;
    logic [VERD_W-1:0]  verdict;
    logic [SEQ_W-1:0]   window_seq;
  } epta_out_t;

  // One classified event on its way from the front end to the counters.
  typedef struct packed {
    logic   valid;
    trans_t trans;
  } epta_evt_t;

endpackage

// File: rtl/core/epta_front.sv
// ----------------------------------------------------------------------------
// epta_front: event intake and pixel polarity store
// Reads each pixel's last polarity, classifies the transition and writes the
// new polarity back, with forwarding between neighbouring transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epta_front import epta_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  epta_in_t  in_data,
  output epta_evt_t evt,
  input  logic      evt_stall
);

  pol_code_t          mem [PIXELS];
  logic               clearing_r;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic               s1_valid_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic               s1_pol_r;
  pol_code_t          rdata_r;
  logic               fwd_hit_r;
  logic               fwd_pol_r;

  logic               in_accept;
  logic               s1_advance;
  logic [ADDR_W-1:0]  in_addr;
  pol_code_t          last_pol;

  assign in_addr    = {COORD_BITS'(in_data.pixel_y), COORD_BITS'(in_data.pixel_x)};
  assign s1_advance = s1_valid_r && !evt_stall;
  assign in_stall   = clearing_r || (s1_valid_r && evt_stall);
  assign in_accept  = in_valid && !in_stall;

  // Single write port: the clearing sweep after reset, then write-back.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= POL_UNSEEN;
    end else if (s1_advance) begin
      mem[s1_addr_r] <= s1_pol_r ? POL_ON : POL_OFF;
    end
    if (in_accept) begin
      rdata_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(PIXELS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // A new event is only taken while the held one moves on, so a matching
  // address means the memory read missed the write made at the same edge.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr_r <= in_addr;
      s1_pol_r  <= in_data.polarity;
      fwd_hit_r <= s1_valid_r && (s1_addr_r == in_addr);
      fwd_pol_r <= s1_pol_r;
    end
  end

  assign last_pol = fwd_hit_r ? (fwd_pol_r ? POL_ON : POL_OFF) : rdata_r;

  always_comb begin
    evt.valid = s1_valid_r;
    evt.trans = TRANS_NONE;
    if (last_pol == POL_ON && !s1_pol_r) begin
      evt.trans = TRANS_FWD;
    end else if (last_pol == POL_OFF && s1_pol_r) begin
      evt.trans = TRANS_REV;
    end
  end

endmodule

// File: rtl/core/epta_queue.sv
// ----------------------------------------------------------------------------
// epta_queue: short queue of classified events
// Decouples the pixel store from the counters so that each side can stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epta_queue import epta_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  epta_evt_t push,
  output logic      push_stall,
  output epta_evt_t pop,
  input  logic      pop_stall
);

  trans_t                 slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_PTR_W:0]   cnt_r;
  logic                   push_ok;
  logic                   pop_ok;

  assign push_stall = (cnt_r == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign pop.valid  = (cnt_r != '0);
  assign pop.trans  = slot_r[rd_ptr_r];
  assign push_ok    = push.valid && !push_stall;
  assign pop_ok     = pop.valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= push.trans;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push_ok, pop_ok})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/core/epta_back.sv
// ----------------------------------------------------------------------------
// epta_back: transition counters, batch and window control, result register
// Counts transitions, closes batches and windows, forms the verdict and
// holds each result until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epta_back import epta_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  epta_evt_t             evt,
  output logic                  evt_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output epta_out_t             out_data
);

  logic [WIN_W-1:0]       win_batches_r;
  logic [MARGIN_W-1:0]    margin_r;
  logic [COUNT_W-1:0]     live_fwd_r;
  logic [COUNT_W-1:0]     live_rev_r;
  logic [COUNT_W-1:0]     held_fwd_r;
  logic [COUNT_W-1:0]     held_rev_r;
  logic [WIN_W-1:0]       batch_cnt_r;
  logic [BATCH_CNT_W-1:0] evt_cnt_r;
  logic [SEQ_W-1:0]       win_seq_r;
  logic                   out_valid_r;
  epta_out_t              out_data_r;

  logic                   batch_end;
  logic                   out_free;
  logic                   take;
  logic                   win_close;
  logic [WIN_W-1:0]       batch_cnt_inc;
  logic [COUNT_W-1:0]     live_fwd_inc;
  logic [COUNT_W-1:0]     live_rev_inc;
  logic [COUNT_W-1:0]     held_fwd_nxt;
  logic [COUNT_W-1:0]     held_rev_nxt;
  logic [SEQ_W-1:0]       win_seq_nxt;
  logic signed [COUNT_W:0] diff_s;
  logic signed [COUNT_W:0] marg_s;
  verdict_t               verdict;

  assign batch_end = (evt_cnt_r == BATCH_CNT_W'(EVENTS_PER_BATCH - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign evt_stall = batch_end && !out_free;
  assign take      = evt.valid && !evt_stall;

  // The running batch count is cleared once it reaches a window length of at
  // most 16 bits, so it never passes 0xFFFE and the sum always fits.
  assign batch_cnt_inc = batch_cnt_r + 1'b1;
  assign win_close     = take && batch_end && (batch_cnt_inc >= win_batches_r);

  assign live_fwd_inc = (evt.trans == TRANS_FWD && live_fwd_r != COUNT_MAX) ?
                        live_fwd_r + 1'b1 : live_fwd_r;
  assign live_rev_inc = (evt.trans == TRANS_REV && live_rev_r != COUNT_MAX) ?
                        live_rev_r + 1'b1 : live_rev_r;

  assign held_fwd_nxt = win_close ? live_fwd_inc : held_fwd_r;
  assign held_rev_nxt = win_close ? live_rev_inc : held_rev_r;
  assign win_seq_nxt  = win_close ? win_seq_r + 1'b1 : win_seq_r;

  always_comb begin
    diff_s = signed'({1'b0, held_fwd_nxt}) - signed'({1'b0, held_rev_nxt});
    marg_s = signed'({1'b0, margin_r});
    if (diff_s >= marg_s) begin
      verdict = VERDICT_FWD;
    end else if (diff_s <= -marg_s) begin
      verdict = VERDICT_BWD;
    end else begin
      verdict = VERDICT_UNDECIDED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_batches_r <= WIN_BATCHES_RESET;
      margin_r      <= MARGIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WINDOW_BATCHES: win_batches_r <= cfg_data;
        CFG_MARGIN:         margin_r      <= cfg_data[MARGIN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_fwd_r  <= '0;
      live_rev_r  <= '0;
      held_fwd_r  <= '0;
      held_rev_r  <= '0;
      batch_cnt_r <= '0;
      evt_cnt_r   <= '0;
      win_seq_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        evt_cnt_r <= batch_end ? '0 : evt_cnt_r + 1'b1;
        if (win_close) begin
          live_fwd_r  <= '0;
          live_rev_r  <= '0;
          batch_cnt_r <= '0;
        end else begin
          live_fwd_r <= live_fwd_inc;
          live_rev_r <= live_rev_inc;
          if (batch_end) begin
            batch_cnt_r <= batch_cnt_inc;
          end
        end
      end
      held_fwd_r <= held_fwd_nxt;
      held_rev_r <= held_rev_nxt;
      win_seq_r  <= win_seq_nxt;
      if (take && batch_end) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && batch_end) begin
      out_data_r.fwd_count  <= held_fwd_nxt;
      out_data_r.rev_count  <= held_rev_nxt;
      out_data_r.verdict    <= verdict;
      out_data_r.window_seq <= win_seq_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_live_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    win_close |=> (live_fwd_r == '0 && live_rev_r == '0))
    else $error("live counts not cleared after a window closed");

  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !win_close |=> ($stable(held_fwd_r) && $stable(held_rev_r)))
    else $error("held counts changed without a window closing");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(take && batch_end))
    else $error("result raised without a batch closing");

endmodule

// File: rtl/core/event_polarity_transition_asymmetry_core.sv
// ----------------------------------------------------------------------------
// event_polarity_transition_asymmetry_core: polarity transition asymmetry
// The event that closes a batch passes the store read register and the queue
// before out_valid rises from the result register.
// Throughput: one event per cycle from the pixel store read-modify-write with
// forwarding; apart from the clearing pass, only a held result stalls input.
// Reset is synchronous; then a clearing pass sweeps all 16384 pixel store
// entries with in_stall high. Window length and margin reset to 256 and 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module event_polarity_transition_asymmetry_core import epta_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  epta_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output epta_out_t             out_data
);

  epta_evt_t front_evt;
  logic      front_stall;
  epta_evt_t back_evt;
  logic      back_stall;

  epta_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .evt       (front_evt),
    .evt_stall (front_stall)
  );

  epta_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_evt),
    .push_stall (front_stall),
    .pop        (back_evt),
    .pop_stall  (back_stall)
  );

  epta_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (back_evt),
    .evt_stall (back_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
